// ===== sv/fsc_pkg.sv =====
// Package for the fuzzy subsequence scorer: register indexes, scoring constants,
// character codes, the query configuration struct and the ASCII case folding function.
// No dependencies.
`default_nettype none

package fsc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_CHARS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_CHARS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_CHARS_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_CHARS_D = 3'd4;

    localparam int CFG_DATA_W = 64;
    localparam int QLEN_W = 6;
    localparam int QCHARS_W = 256;
    localparam int QIDX_W = 5;

    // Scoring constants
    localparam logic [6:0] BONUS_START = 7'd15;
    localparam logic [6:0] BONUS_CHAIN = 7'd15;
    localparam logic [6:0] BONUS_SEP = 7'd30;
    localparam logic [6:0] BONUS_CAMEL = 7'd30;
    localparam int LEAD_PENALTY = 5;
    localparam logic [1:0] LEAD_MAX = 2'd3;

    // Character codes
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] SEP_SLASH = 8'h2F;
    localparam logic [7:0] SEP_BSLASH = 8'h5C;
    localparam logic [7:0] SEP_UNDER = 8'h5F;
    localparam logic [7:0] SEP_DASH = 8'h2D;
    localparam logic [7:0] SEP_DOT = 8'h2E;
    localparam logic [7:0] SEP_SPACE = 8'h20;

    typedef struct packed {
        logic [QLEN_W-1:0]   length;
        logic [QCHARS_W-1:0] chars;
    } query_cfg_t;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fsc_cfg_if.sv =====
// Configuration write channel: register index and write data with valid/ready.
// Depends on fsc_pkg.
`default_nettype none

interface fsc_cfg_if
    import fsc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/fsc_in_if.sv =====
// Candidate byte channel: one byte item per handshake with valid/ready.
// No dependencies.
`default_nettype none

interface fsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] cand_char;
    logic       char_valid;
    logic       last_char;

    modport source (output valid, output cand_char, output char_valid, output last_char,
                    input ready);
    modport sink (input valid, input cand_char, input char_valid, input last_char,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/fsc_out_if.sv =====
// Result channel: final score and full-match flag with valid/ready.
// No dependencies.
`default_nettype none

interface fsc_out_if #(
    parameter int SCORE_WIDTH = 14
);
    logic                          valid;
    logic                          ready;
    logic signed [SCORE_WIDTH-1:0] match_score;
    logic                          full_match;

    modport source (output valid, output match_score, output full_match, input ready);
    modport sink (input valid, input match_score, input full_match, output ready);
endinterface

`default_nettype wire

// ===== sv/fsc_cfg_regs.sv =====
// Configuration register file: query length and the 32 query characters.
// Depends on fsc_pkg and fsc_cfg_if.
`default_nettype none

module fsc_cfg_regs
    import fsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fsc_cfg_if.sink   cfg,
    output query_cfg_t qcfg
);

    logic [QLEN_W-1:0]     query_length_reg;
    logic [CFG_DATA_W-1:0] chars_a_reg;
    logic [CFG_DATA_W-1:0] chars_b_reg;
    logic [CFG_DATA_W-1:0] chars_c_reg;
    logic [CFG_DATA_W-1:0] chars_d_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_length_reg <= '0;
            chars_a_reg      <= '0;
            chars_b_reg      <= '0;
            chars_c_reg      <= '0;
            chars_d_reg      <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_QUERY_LENGTH:  query_length_reg <= cfg.data[QLEN_W-1:0];
                REG_QUERY_CHARS_A: chars_a_reg <= cfg.data;
                REG_QUERY_CHARS_B: chars_b_reg <= cfg.data;
                REG_QUERY_CHARS_C: chars_c_reg <= cfg.data;
                REG_QUERY_CHARS_D: chars_d_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign qcfg.length = query_length_reg;
    assign qcfg.chars  = {chars_d_reg, chars_c_reg, chars_b_reg, chars_a_reg};

endmodule

`default_nettype wire

// ===== sv/fsc_score_core.sv =====
// Per-byte scoring logic and the candidate state registers; gives the final
// result for the byte that closes a candidate. Depends on fsc_pkg.
`default_nettype none

module fsc_score_core
    import fsc_pkg::*;
#(
    parameter int QUERY_MAX = 32,
    parameter int SCORE_WIDTH = 14
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [7:0]                    cand_char,
    input  wire logic                          char_valid,
    input  wire logic                          last_char,
    input  wire query_cfg_t                    qcfg,
    output logic signed [SCORE_WIDTH-1:0]      res_score,
    output logic                               res_full
);

    localparam int PW = $clog2(QUERY_MAX + 1);
    localparam int SW = SCORE_WIDTH;

    logic [PW-1:0]        pos_reg, pos_next;
    logic                 prev_matched_reg, prev_matched_next;
    logic                 prev_sep_reg, prev_sep_next;
    logic                 prev_upper_reg, prev_upper_next;
    logic                 at_start_reg, at_start_next;
    logic [1:0]           lead_reg, lead_next;
    logic signed [SW-1:0] score_reg, score_next;

    logic [PW-1:0]        len_eff;
    logic [QIDX_W-1:0]    qidx;
    logic [7:0]           qbyte;
    logic                 is_up, is_sep, hit;
    logic [6:0]           gain;
    logic signed [SW:0]   sum, fin_sum;
    logic signed [SW-1:0] sum_sat, fin_sat;
    logic [3:0]           penalty;

    // A programmed length above the storage depth acts as the full depth.
    assign len_eff = (qcfg.length > QLEN_W'(QUERY_MAX)) ? PW'(QUERY_MAX) : PW'(qcfg.length);
    assign qidx    = QIDX_W'(pos_reg);
    assign qbyte   = qcfg.chars[{qidx, 3'b000} +: 8];

    assign is_up  = cand_char inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
    assign is_sep = cand_char inside {SEP_SLASH, SEP_BSLASH, SEP_UNDER, SEP_DASH, SEP_DOT,
                                      SEP_SPACE};
    assign hit    = (pos_reg < len_eff) && (fold_lower(qbyte) == fold_lower(cand_char));

    always_comb
    begin
        gain = '0;
        if (at_start_reg)
            gain = gain + BONUS_START;
        if (prev_matched_reg)
            gain = gain + BONUS_CHAIN;
        if (prev_sep_reg)
            gain = gain + BONUS_SEP;
        // Camel step: upper case after a byte that was not upper case, past the first query character.
        if ((pos_reg != '0) && is_up && !(prev_upper_reg && !at_start_reg))
            gain = gain + BONUS_CAMEL;
    end

    always_comb
    begin
        if (hit)
            sum = {score_reg[SW-1], score_reg} + $signed({{(SW-6){1'b0}}, gain});
        else
            sum = {score_reg[SW-1], score_reg} - (SW+1)'(1);
        if (sum[SW] != sum[SW-1])
            sum_sat = sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        else
            sum_sat = sum[SW-1:0];
    end

    always_comb
    begin
        pos_next          = pos_reg;
        prev_matched_next = prev_matched_reg;
        prev_sep_next     = prev_sep_reg;
        prev_upper_next   = prev_upper_reg;
        at_start_next     = at_start_reg;
        lead_next         = lead_reg;
        score_next        = score_reg;
        if (char_valid)
        begin
            score_next        = sum_sat;
            prev_matched_next = hit;
            prev_sep_next     = is_sep;
            prev_upper_next   = is_up;
            at_start_next     = 1'b0;
            if (hit)
                pos_next = pos_reg + PW'(1);
            else if ((pos_reg == '0) && (lead_reg != LEAD_MAX))
                lead_next = lead_reg + 2'd1;
        end
    end

    assign penalty = 4'(lead_next * LEAD_PENALTY);

    always_comb
    begin
        fin_sum = {score_next[SW-1], score_next} - $signed({{(SW-3){1'b0}}, penalty});
        if (fin_sum[SW] != fin_sum[SW-1])
            fin_sat = fin_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        else
            fin_sat = fin_sum[SW-1:0];
    end

    assign res_full  = (len_eff != '0) && !at_start_next && (pos_next == len_eff);
    assign res_score = res_full ? fin_sat : '0;

    // The byte that closes a candidate puts all candidate state back to its start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            prev_matched_reg <= 1'b0;
            prev_sep_reg     <= 1'b1;
            prev_upper_reg   <= 1'b0;
            at_start_reg     <= 1'b1;
            lead_reg         <= '0;
            score_reg        <= '0;
        end
        else if (step)
        begin
            if (last_char)
            begin
                pos_reg          <= '0;
                prev_matched_reg <= 1'b0;
                prev_sep_reg     <= 1'b1;
                prev_upper_reg   <= 1'b0;
                at_start_reg     <= 1'b1;
                lead_reg         <= '0;
                score_reg        <= '0;
            end
            else
            begin
                pos_reg          <= pos_next;
                prev_matched_reg <= prev_matched_next;
                prev_sep_reg     <= prev_sep_next;
                prev_upper_reg   <= prev_upper_next;
                at_start_reg     <= at_start_next;
                lead_reg         <= lead_next;
                score_reg        <= score_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/fuzzy_subsequence_scorer.sv =====
// Top level of the fuzzy subsequence scorer: input register, scoring core and
// result register. Depends on fsc_pkg, the three channel interfaces,
// fsc_cfg_regs and fsc_score_core.
//
// Usage: write the query length and up to 32 query characters on the cfg
// channel while the block is idle; cfg is always ready. Then stream the
// candidate one byte item per cycle on the cand channel, the final item marked
// with last_char. An item with char_valid low changes no score state, so a
// lone item with char_valid low and last_char high scores an empty candidate.
// The result channel carries one item per candidate: match_score and full_match.
// A closing item passes through the input register and then the result register.
// Throughput: one candidate byte per cycle while no closing byte is held, set by the single registered
// scoring step between the input register and the per-candidate state.
// When the result channel stalls, bytes that do not close a candidate keep
// flowing; a closing byte waits in the input register until the result
// register is free, and cand.ready drops only then.
// Reset clears the configuration registers, the candidate state and the valid
// bits of both pipeline registers.
`default_nettype none

module fuzzy_subsequence_scorer
    import fsc_pkg::*;
#(
    parameter int QUERY_MAX = 32,
    parameter int SCORE_WIDTH = 14
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fsc_cfg_if.sink    cfg,
    fsc_in_if.sink     cand,
    fsc_out_if.source  result
);

    query_cfg_t qcfg;

    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_cvalid_reg;
    logic       s1_last_reg;
    logic       s1_adv;

    logic                          out_valid_reg;
    logic signed [SCORE_WIDTH-1:0] out_score_reg;
    logic                          out_full_reg;

    logic signed [SCORE_WIDTH-1:0] res_score;
    logic                          res_full;

    fsc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .qcfg  (qcfg)
    );

    fsc_score_core #(
        .QUERY_MAX   (QUERY_MAX),
        .SCORE_WIDTH (SCORE_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_adv),
        .cand_char  (s1_char_reg),
        .char_valid (s1_cvalid_reg),
        .last_char  (s1_last_reg),
        .qcfg       (qcfg),
        .res_score  (res_score),
        .res_full   (res_full)
    );

    // Only an item that closes a candidate needs room in the result register.
    assign s1_adv     = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign cand.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cand.ready)
        begin
            s1_valid_reg <= cand.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand.valid && cand.ready)
        begin
            s1_char_reg   <= cand.cand_char;
            s1_cvalid_reg <= cand.char_valid;
            s1_last_reg   <= cand.last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            out_score_reg <= res_score;
            out_full_reg  <= res_full;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.match_score = out_score_reg;
    assign result.full_match  = out_full_reg;

    // A result without a full match always carries a zero score.
    a_zero_without_match: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.full_match) |-> (result.match_score == '0))
        else $error("nonzero score without full match");

    // The input side stalls only behind a closing item blocked by the result side.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cand.ready |-> (s1_valid_reg && s1_last_reg && out_valid_reg && !result.ready))
        else $error("input stalled without a blocked closing item");

    // A new result appears only after a closing item left the input register.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(s1_adv && s1_last_reg))
        else $error("result appeared without a closing item");

endmodule

`default_nettype wire

// ===== bench/fuzzy_subsequence_scorer_checker.sv =====
// Scoreboard for the fuzzy subsequence scorer: watches the cfg, candidate and result
// channels, keeps its own copy of the query and the per-candidate state, and
// compares every result item with its prediction. Depends on fsc_pkg and the interfaces.
module fuzzy_subsequence_scorer_checker
    import fsc_pkg::*;
#(
    parameter int QUERY_MAX = 32,
    parameter int SCORE_WIDTH = 14
) (
    input  logic clk,
    input  logic rst_n,
    fsc_cfg_if   cfg,
    fsc_in_if    cand,
    fsc_out_if   result,
    output int   mismatches,
    output int   scores_pending
);

    localparam int GAIN_START = 15;
    localparam int GAIN_CHAIN = 15;
    localparam int GAIN_SEP = 30;
    localparam int GAIN_CAMEL = 30;
    localparam int MISS_COST = 1;
    localparam int LEAD_COST = 5;
    localparam int LEAD_CAP = 3;
    localparam int SCORE_HI = (1 << (SCORE_WIDTH - 1)) - 1;
    localparam int SCORE_LO = -SCORE_HI - 1;

    typedef struct packed {
        logic signed [SCORE_WIDTH-1:0] score;
        logic                          full;
    } verdict_t;

    verdict_t expected_scores[$];

    logic [QLEN_W-1:0] query_len;
    logic [63:0]       query_word[4];

    int match_pos;
    bit last_matched;
    bit last_sep;
    bit last_upper;
    bit fresh;
    int lead_bytes;
    int running;

    function automatic int saturate(input int v);
        if (v > SCORE_HI)
        begin
            return SCORE_HI;
        end
        if (v < SCORE_LO)
        begin
            return SCORE_LO;
        end
        return v;
    endfunction

    function automatic bit is_upper(input logic [7:0] c);
        return c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return is_upper(c) ? c + CASE_OFFSET : c;
    endfunction

    function automatic bit is_sep(input logic [7:0] c);
        return c == SEP_SLASH || c == SEP_BSLASH || c == SEP_UNDER || c == SEP_DASH
            || c == SEP_DOT || c == SEP_SPACE;
    endfunction

    function automatic logic [7:0] query_byte(input int i);
        return query_word[(i >> 3) & 3][(i & 7) * 8 +: 8];
    endfunction

    task automatic clear_candidate();
        match_pos = 0;
        last_matched = 1'b0;
        last_sep = 1'b1;
        last_upper = 1'b0;
        fresh = 1'b1;
        lead_bytes = 0;
        running = 0;
    endtask

    task automatic score_byte(input logic [7:0] c, input logic real_byte, input logic closing);
        int used;
        int gain;
        verdict_t v;
        used = (int'(query_len) > QUERY_MAX) ? QUERY_MAX : int'(query_len);
        if (real_byte)
        begin
            if (match_pos < used && to_lower(query_byte(match_pos)) == to_lower(c))
            begin
                gain = 0;
                if (fresh)
                begin
                    gain += GAIN_START;
                end
                if (last_matched)
                begin
                    gain += GAIN_CHAIN;
                end
                if (last_sep)
                begin
                    gain += GAIN_SEP;
                end
                // Camel step: an upper-case byte after a non-upper one, past the
                // first query character.
                if (match_pos > 0 && is_upper(c) && !(last_upper && !fresh))
                begin
                    gain += GAIN_CAMEL;
                end
                running = saturate(running + gain);
                match_pos++;
                last_matched = 1'b1;
            end
            else
            begin
                if (match_pos == 0 && lead_bytes < LEAD_CAP)
                begin
                    lead_bytes++;
                end
                running = saturate(running - MISS_COST);
                last_matched = 1'b0;
            end
            last_sep = is_sep(c);
            last_upper = is_upper(c);
            fresh = 1'b0;
        end
        if (closing)
        begin
            v.score = '0;
            v.full = 1'b0;
            if (used != 0 && !fresh && match_pos == used)
            begin
                v.full = 1'b1;
                v.score = SCORE_WIDTH'(saturate(running - LEAD_COST * lead_bytes));
            end
            expected_scores.insert(expected_scores.size(), v);
            clear_candidate();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("checker: %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_len = '0;
            for (int i = 0; i < 4; i++)
            begin
                query_word[i] = '0;
            end
            clear_candidate();
            expected_scores.delete();
            mismatches = 0;
            scores_pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_QUERY_LENGTH:  query_len = cfg.data[QLEN_W-1:0];
                    REG_QUERY_CHARS_A: query_word[0] = cfg.data;
                    REG_QUERY_CHARS_B: query_word[1] = cfg.data;
                    REG_QUERY_CHARS_C: query_word[2] = cfg.data;
                    REG_QUERY_CHARS_D: query_word[3] = cfg.data;
                    default: ;
                endcase
            end
            if (cand.valid && cand.ready)
            begin
                score_byte(cand.cand_char, cand.char_valid, cand.last_char);
            end
            if (result.valid && result.ready)
            begin
                if (expected_scores.size() == 0)
                begin
                    report_mismatch("result item with no score waiting",
                                    int'($signed(result.match_score)), 0);
                end
                else
                begin
                    verdict_t v;
                    v = expected_scores.pop_front();
                    if (result.match_score !== v.score)
                    begin
                        report_mismatch("match_score", int'($signed(result.match_score)),
                                        int'($signed(v.score)));
                    end
                    if (result.full_match !== v.full)
                    begin
                        report_mismatch("full_match", int'(result.full_match), int'(v.full));
                    end
                end
            end
            scores_pending = expected_scores.size();
        end
    end

endmodule

// ===== bench/fuzzy_subsequence_scorer_tb.sv =====
// Top of the fuzzy subsequence scorer bench: clock, reset, query setup, candidate
// stimulus and result back-pressure, with the verdict taken from the checker's count.
// Depends on fsc_pkg, the channel interfaces, the block and fuzzy_subsequence_scorer_checker.
module fuzzy_subsequence_scorer_tb;
    import fsc_pkg::*;

    localparam int QUERY_MAX = 32;
    localparam int SCORE_WIDTH = 14;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int HOLD_PHASE = 5;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_RUN_BYTES = 40;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef enum int {QUERY_WORDS, QUERY_ANY_BYTE, QUERY_ALL_ONES} query_flavor_t;
    typedef enum int {CAND_FULL, CAND_PARTIAL, CAND_NOISE} cand_kind_t;
    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} ready_mode_t;

    localparam int PHASE_LEN[PHASES] = '{1, 32, 40, 0, 63, 5, 12, 3, 8, 2};
    localparam query_flavor_t PHASE_FLAVOR[PHASES] = '{
        QUERY_WORDS, QUERY_ALL_ONES, QUERY_ANY_BYTE, QUERY_WORDS, QUERY_WORDS,
        QUERY_WORDS, QUERY_ANY_BYTE, QUERY_WORDS, QUERY_WORDS, QUERY_ALL_ONES};
    localparam logic [CFG_IDX_W-1:0] CHAR_REGS[4] = '{
        REG_QUERY_CHARS_A, REG_QUERY_CHARS_B, REG_QUERY_CHARS_C, REG_QUERY_CHARS_D};
    localparam logic [7:0] SEPARATORS[6] = '{
        SEP_SLASH, SEP_BSLASH, SEP_UNDER, SEP_DASH, SEP_DOT, SEP_SPACE};

    logic clk = 1'b0;
    logic rst_n;

    always #1 clk = ~clk;

    fsc_cfg_if cfg_ch ();
    fsc_in_if cand_ch ();
    fsc_out_if #(.SCORE_WIDTH(SCORE_WIDTH)) res_ch ();

    fuzzy_subsequence_scorer #(
        .QUERY_MAX(QUERY_MAX),
        .SCORE_WIDTH(SCORE_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_ch),
        .cand(cand_ch),
        .result(res_ch)
    );

    int mismatches;
    int scores_pending;

    fuzzy_subsequence_scorer_checker #(
        .QUERY_MAX(QUERY_MAX),
        .SCORE_WIDTH(SCORE_WIDTH)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_ch),
        .cand(cand_ch),
        .result(res_ch),
        .mismatches(mismatches),
        .scores_pending(scores_pending)
    );

    logic [7:0] query[QUERY_MAX];
    int         query_used;
    logic [8:0] cand_bytes[$];
    int         burst_left;
    bit         hold_request;

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(0, 25));
        return $urandom_range(0, 1) ? c - CASE_OFFSET : c;
    endfunction

    function automatic logic [7:0] pick_noise();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            return 8'($urandom_range(0, 255));
        end
        if (r < 7)
        begin
            return random_letter();
        end
        if (r < 9)
        begin
            return SEPARATORS[$urandom_range(0, 5)];
        end
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_query_char(input query_flavor_t flavor);
        case (flavor)
            QUERY_ANY_BYTE: return 8'($urandom_range(0, 255));
            QUERY_ALL_ONES: return 8'hFF;
            default:        return pick_noise();
        endcase
    endfunction

    function automatic logic [7:0] vary_case(input logic [7:0] c);
        if (is_alpha(c) && $urandom_range(0, 1))
        begin
            return c ^ CASE_OFFSET;
        end
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Writes every query register; junk above the length field must be ignored.
    task automatic write_query(input int len);
        logic [CFG_DATA_W-1:0] w;
        w = {$urandom(), $urandom()};
        w[QLEN_W-1:0] = len[QLEN_W-1:0];
        write_reg(REG_QUERY_LENGTH, w);
        for (int j = 0; j < 4; j++)
        begin
            for (int b = 0; b < 8; b++)
            begin
                w[b * 8 +: 8] = query[j * 8 + b];
            end
            write_reg(CHAR_REGS[j], w);
        end
        query_used = (len > QUERY_MAX) ? QUERY_MAX : len;
    endtask

    task automatic send_byte(input logic [7:0] c, input logic real_byte, input logic closing);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                cand_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(20, 80);
        end
        cand_ch.valid = 1'b1;
        cand_ch.cand_char = c;
        cand_ch.char_valid = real_byte;
        cand_ch.last_char = closing;
        @(posedge clk);
        while (!cand_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        burst_left--;
    endtask

    // Valid stays high on return so that the next item can follow with no gap.
    task automatic send_candidate();
        for (int i = 0; i < cand_bytes.size(); i++)
        begin
            send_byte(cand_bytes[i][7:0], cand_bytes[i][8], i == cand_bytes.size() - 1);
        end
    endtask

    task automatic add_byte(input logic [8:0] b);
        cand_bytes.insert(cand_bytes.size(), b);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_byte({1'b1, s[i]});
        end
    endtask

    task automatic build_candidate(input cand_kind_t kind);
        int stop;
        cand_bytes.delete();
        if (kind == CAND_NOISE)
        begin
            repeat ($urandom_range(0, 6)) add_byte({1'b1, pick_noise()});
        end
        else
        begin
            stop = query_used;
            if (kind == CAND_PARTIAL)
            begin
                stop = $urandom_range(0, (query_used > 0) ? query_used - 1 : 0);
            end
            for (int i = 0; i < stop; i++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    repeat ($urandom_range(1, 4)) add_byte({1'b1, pick_noise()});
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    add_byte({1'b0, 8'($urandom_range(0, 255))});
                end
                add_byte({1'b1, vary_case(query[i])});
            end
            if ($urandom_range(0, 2) == 0)
            begin
                repeat ($urandom_range(1, 3)) add_byte({1'b1, pick_noise()});
            end
        end
        // Sometimes, and always when it is empty, the candidate is closed by an item that carries no byte.
        if (cand_bytes.size() == 0 || $urandom_range(0, 5) == 0)
        begin
            add_byte({1'b0, 8'($urandom_range(0, 255))});
        end
    endtask

    task automatic settle();
        cand_ch.valid = 1'b0;
        while (scores_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin : receiver
        ready_mode_t mode;
        int span;
        bit held;
        res_ch.ready = 1'b0;
        held = 1'b0;
        forever
        begin
            mode = ready_mode_t'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            for (int k = 0; k < span; k++)
            begin
                @(negedge clk);
                if (hold_request && !held)
                begin
                    held = 1'b1;
                    res_ch.ready = 1'b0;
                    repeat (LONG_HOLD_CYCLES) @(negedge clk);
                end
                case (mode)
                    READY_ALWAYS: res_ch.ready = 1'b1;
                    READY_COIN:   res_ch.ready = 1'($urandom_range(0, 1));
                    READY_SPARSE: res_ch.ready = (k % 4 == 0);
                    default:      res_ch.ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("fuzzy_subsequence_scorer_tb: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int phase_items;
        int r;
        logic [7:0] c;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        cand_ch.valid = 1'b0;
        cand_ch.cand_char = '0;
        cand_ch.char_valid = 1'b0;
        cand_ch.last_char = 1'b0;
        burst_left = 0;
        hold_request = 1'b0;
        query_used = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty query straight out of reset.
        cand_bytes.delete();
        push_text("a");
        send_candidate();
        settle();

        for (int i = 0; i < QUERY_MAX; i++)
        begin
            query[i] = pick_query_char(QUERY_WORDS);
        end
        query[0] = "f";
        query[1] = "o";
        query[2] = "_";
        query[3] = "b";
        write_query(4);

        // Start, chain, separator and camel bonuses with case folding.
        cand_bytes.delete();
        push_text("Fo_B");
        send_candidate();
        // Leading penalty past its cap.
        cand_bytes.delete();
        push_text("zzzzzfo_b");
        send_candidate();
        // Incomplete match closed by an item without a byte.
        cand_bytes.delete();
        push_text("fXo");
        add_byte({1'b0, 8'h62});
        send_candidate();
        // Empty candidate.
        cand_bytes.delete();
        add_byte({1'b0, 8'hFF});
        send_candidate();
        // A byte-less item in the middle leaves the state alone.
        cand_bytes.delete();
        push_text("f");
        add_byte({1'b0, 8'h6F});
        push_text("o_b");
        send_candidate();
        settle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int i = 0; i < QUERY_MAX; i++)
            begin
                query[i] = pick_query_char(PHASE_FLAVOR[ph]);
            end
            write_query(PHASE_LEN[ph]);
            if (ph == HOLD_PHASE)
            begin
                hold_request = 1'b1;
            end
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                r = $urandom_range(0, 19);
                build_candidate((r < 14) ? CAND_FULL : ((r < 17) ? CAND_PARTIAL : CAND_NOISE));
                send_candidate();
                phase_items += cand_bytes.size();
            end
            settle();
        end

        // A long run of misses with a single match at its very end.
        query[0] = "q";
        write_query(1);
        cand_bytes.delete();
        repeat (LONG_RUN_BYTES)
        begin
            do
            begin
                c = pick_noise();
            end
            while (c == "q" || c == "Q");
            add_byte({1'b1, c});
        end
        push_text("Q");
        send_candidate();
        settle();

        if (mismatches == 0 && scores_pending == 0)
        begin
            $display("fuzzy_subsequence_scorer_tb: done, clean");
        end
        else
        begin
            $display("fuzzy_subsequence_scorer_tb: done, errors");
        end
        $finish;
    end

endmodule
